### design/hsa_pkg.sv
// ----------------------------------------------------------------------------
// hsa_pkg
// Shared types, constants and helper functions for the saturation adjust
// pipeline: fixed-point formats, hue sectors and the long-division step.
// ----------------------------------------------------------------------------
package hsa_pkg;

  // Pixel channel width and the Q1.16 value of one.
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned FRAC_W = 16;
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Gain register format and reset value (1.0 in Q4.12).
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned GAIN_FRAC_BITS_DEF = 12;
  localparam logic [15:0] SAT_GAIN_RESET = 16'd4096;

  // Hue numerator is below six times the largest delta, so 11 bits hold it.
  localparam int unsigned HUE_W = 11;

  // Quotient bits produced by each divider: sector (3 bits) over fraction.
  localparam int unsigned QUO_W = 19;

  // Division steps done in each of the four divider stages.
  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned DIV_STEPS_MAX = 5;
  localparam int unsigned DIV_STEPS [DIV_STAGES] = '{5, 5, 5, 4};

  // Total pipeline depth, input register to output register.
  localparam int unsigned NUM_STAGES = 8;

  // Hexcone sectors, named after the colour at which each one starts.
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_e;

  // Partial state of one restoring divider.
  typedef struct packed {
    logic [CHAN_W-1:0] rem;   // running remainder, always below the divisor
    logic [QUO_W-1:0]  quo;   // quotient bits produced so far
    logic [QUO_W-1:0]  feed;  // dividend bits still to shift in, MSB first
  } div_t;

  // Payload of one divider pipeline stage.
  typedef struct packed {
    div_t              sat;     // delta * 2^16 / max
    div_t              hue;     // hue * 2^16 / delta
    logic [CHAN_W-1:0] sat_den; // max, forced to one for black
    logic [CHAN_W-1:0] hue_den; // delta, forced to one for gray
    logic [CHAN_W-1:0] val;     // value, the largest channel
    logic              last;
  } dv_t;

  // Runs a number of restoring division steps on one divider state.
  function automatic div_t div_run(div_t x, logic [CHAN_W-1:0] den, int unsigned steps);
    div_t        y;
    logic [CHAN_W:0] r9;
    y = x;
    for (int unsigned i = 0; i < DIV_STEPS_MAX; i++) begin
      if (i < steps) begin
        r9     = {y.rem, y.feed[QUO_W-1]};
        y.feed = {y.feed[QUO_W-2:0], 1'b0};
        if (r9 >= {1'b0, den}) begin
          y.rem = CHAN_W'(r9 - {1'b0, den});
          y.quo = {y.quo[QUO_W-2:0], 1'b1};
        end else begin
          y.rem = r9[CHAN_W-1:0];
          y.quo = {y.quo[QUO_W-2:0], 1'b0};
        end
      end
    end
    return y;
  endfunction

  // Scales a channel by a Q1.16 factor and truncates: floor(v * k / 2^16).
  function automatic logic [CHAN_W-1:0] scale_q16(logic [CHAN_W-1:0] v, logic [16:0] k);
    logic [24:0] prod;
    prod = {17'b0, v} * {8'b0, k};
    return prod[23:16];
  endfunction

endpackage

### design/hsv_saturation_adjust.sv
// ----------------------------------------------------------------------------
// hsv_saturation_adjust
// Streaming RGB888 saturation adjust through the hexcone HSV model, with a
// configurable Q4.12 saturation gain.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Ports                    Payload
//  s_axis    in         tvalid/tready/tdata/tlast  red, green, blue, last
//  m_axis    out        tvalid/tready/tdata/tlast  red, green, blue, last
//  cfg       in         valid/ready/data           sat_gain (16 bits)
//
//  One pixel is taken per clock unless m_axis stalls; there are eight
//  register stages: min/max and hue, four stages of the two restoring
//  dividers (five, five, five and four quotient bits), the gain multiply,
//  the clamp with the q/t products, and the p/q/t scaling with the output.
//  Each stage holds its pixel while the one after it is full and held, so a stall
//  on m_axis backs up stage by stage and nothing is lost or repeated.
//  Reset clears only the valid bits and restores the gain to 1.0; there is
//  no clearing pass. The gain register takes a write in every cycle.
//
module hsv_saturation_adjust #(
  parameter int unsigned GAIN_FRAC_BITS = hsa_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Input pixels. tdata: red_in [7:0], green_in [15:8], blue_in [23:16].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // last_in

  // Output pixels. tdata: red_out [7:0], green_out [15:8], blue_out [23:16].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,   // last_out

  // Saturation gain write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned NS = hsa_pkg::NUM_STAGES;
  localparam int unsigned CW = hsa_pkg::CHAN_W;
  localparam int unsigned PROD_W = 17 + hsa_pkg::GAIN_W;

  // Gain register.
  logic [hsa_pkg::GAIN_W-1:0] gain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= hsa_pkg::SAT_GAIN_RESET;
    end else if (cfg_valid_i) begin
      gain_q <= cfg_data_i;
    end
  end

  // Stage valid bits and the load enables, which ripple back from the output.
  logic [NS-1:0] valid_q;
  logic [NS-1:0] load;

  always_comb begin
    load[NS-1] = !valid_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  assign s_axis_tready = load[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (load[0]) begin
        valid_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (load[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Stage 0: max, min, delta and the offset hue numerator.
  logic [CW-1:0]               red, green, blue;
  logic [CW-1:0]               mx, mn, delta;
  logic [hsa_pkg::HUE_W-1:0]   hue;
  logic [hsa_pkg::HUE_W-1:0]   dl_w;
  hsa_pkg::dv_t                dv_d0;

  assign red   = s_axis_tdata[7:0];
  assign green = s_axis_tdata[15:8];
  assign blue  = s_axis_tdata[23:16];

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;
    dl_w  = {3'b0, delta};

    // Red is tested first, then green, as the hexcone formula orders them.
    if (red == mx) begin
      if (green >= blue) begin
        hue = {3'b0, green - blue};
      end else begin
        hue = (dl_w * 11'd6) - {3'b0, blue - green};
      end
    end else if (green == mx) begin
      hue = (dl_w << 1) + {3'b0, blue} - {3'b0, red};
    end else begin
      hue = (dl_w << 2) + {3'b0, red} - {3'b0, green};
    end

    // The quotients are known to fit 19 bits, so the top dividend bits
    // already form the first remainder. A gray or black pixel has zero delta,
    // so zero saturation and the gray output; a zero divisor is forced to one.
    dv_d0.sat.rem  = {3'b0, delta[7:3]};
    dv_d0.sat.quo  = '0;
    dv_d0.sat.feed = {delta[2:0], 16'b0};
    dv_d0.hue.rem  = hue[10:3];
    dv_d0.hue.quo  = '0;
    dv_d0.hue.feed = {hue[2:0], 16'b0};
    dv_d0.sat_den  = (mx == '0) ? CW'(1) : mx;
    dv_d0.hue_den  = (delta == '0) ? CW'(1) : delta;
    dv_d0.val      = mx;
    dv_d0.last     = s_axis_tlast;
  end

  // Stages 0 to 4: divider pipeline.
  hsa_pkg::dv_t dv_q [hsa_pkg::DIV_STAGES+1];
  hsa_pkg::dv_t dv_d [hsa_pkg::DIV_STAGES+1];

  always_comb begin
    dv_d[0] = dv_d0;
    for (int k = 1; k <= hsa_pkg::DIV_STAGES; k++) begin
      dv_d[k]     = dv_q[k-1];
      dv_d[k].sat = hsa_pkg::div_run(dv_q[k-1].sat, dv_q[k-1].sat_den,
                                     hsa_pkg::DIV_STEPS[k-1]);
      dv_d[k].hue = hsa_pkg::div_run(dv_q[k-1].hue, dv_q[k-1].hue_den,
                                     hsa_pkg::DIV_STEPS[k-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= hsa_pkg::DIV_STAGES; k++) begin
      if (load[k]) begin
        dv_q[k] <= dv_d[k];
      end
    end
  end

  // Stage 5: saturation times gain.
  localparam int unsigned S5 = hsa_pkg::DIV_STAGES + 1;
  hsa_pkg::dv_t               dv_last;
  logic [PROD_W-1:0]          prod_d, prod_q;
  logic [hsa_pkg::FRAC_W-1:0] frac_q;
  hsa_pkg::sector_e           sec5_q;
  logic [CW-1:0]              val5_q;
  logic                       last5_q;

  assign dv_last = dv_q[hsa_pkg::DIV_STAGES];
  assign prod_d  = {{(PROD_W-17){1'b0}}, dv_last.sat.quo[16:0]}
                 * {{(PROD_W-hsa_pkg::GAIN_W){1'b0}}, gain_q};

  always_ff @(posedge clk_i) begin
    if (load[S5]) begin
      prod_q  <= prod_d;
      frac_q  <= dv_last.hue.quo[15:0];
      sec5_q  <= hsa_pkg::sector_e'(dv_last.hue.quo[18:16]);
      val5_q  <= dv_last.val;
      last5_q <= dv_last.last;
    end
  end

  // Stage 6: clamp the scaled saturation to one and form s*f and s*(1-f).
  logic [PROD_W-1:0]  shifted;
  logic [16:0]        sc_d, sc_q;
  logic [33:0]        sf_full, st_full;
  logic [16:0]        sf_q, st_q;
  hsa_pkg::sector_e   sec6_q;
  logic [CW-1:0]      val6_q;
  logic               last6_q;

  always_comb begin
    shifted = prod_q >> GAIN_FRAC_BITS;
    if (shifted > PROD_W'(hsa_pkg::ONE_Q16)) begin
      sc_d = hsa_pkg::ONE_Q16;
    end else begin
      sc_d = shifted[16:0];
    end
    sf_full = {17'b0, sc_d} * {18'b0, frac_q};
    st_full = {17'b0, sc_d} * {17'b0, hsa_pkg::ONE_Q16 - {1'b0, frac_q}};
  end

  always_ff @(posedge clk_i) begin
    if (load[S5+1]) begin
      sc_q    <= sc_d;
      sf_q    <= sf_full[32:16];
      st_q    <= st_full[32:16];
      sec6_q  <= sec5_q;
      val6_q  <= val5_q;
      last6_q <= last5_q;
    end
  end

  // Stage 7: p, q and t, then the channels for the hue sector.
  logic [CW-1:0] pv, qv, tv;
  logic [CW-1:0] ro_d, go_d, bo_d;
  logic [CW-1:0] ro_q, go_q, bo_q;
  logic          last7_q;

  always_comb begin
    pv = hsa_pkg::scale_q16(val6_q, hsa_pkg::ONE_Q16 - sc_q);
    qv = hsa_pkg::scale_q16(val6_q, hsa_pkg::ONE_Q16 - sf_q);
    tv = hsa_pkg::scale_q16(val6_q, hsa_pkg::ONE_Q16 - st_q);
    case (sec6_q)
      hsa_pkg::SEC_RED: begin
        ro_d = val6_q; go_d = tv;     bo_d = pv;
      end
      hsa_pkg::SEC_YELLOW: begin
        ro_d = qv;     go_d = val6_q; bo_d = pv;
      end
      hsa_pkg::SEC_GREEN: begin
        ro_d = pv;     go_d = val6_q; bo_d = tv;
      end
      hsa_pkg::SEC_CYAN: begin
        ro_d = pv;     go_d = qv;     bo_d = val6_q;
      end
      hsa_pkg::SEC_BLUE: begin
        ro_d = tv;     go_d = pv;     bo_d = val6_q;
      end
      hsa_pkg::SEC_MAGENTA: begin
        ro_d = val6_q; go_d = pv;     bo_d = qv;
      end
      default: begin
        ro_d = val6_q; go_d = pv;     bo_d = qv;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load[NS-1]) begin
      ro_q    <= ro_d;
      go_q    <= go_d;
      bo_q    <= bo_d;
      last7_q <= last6_q;
    end
  end

  assign m_axis_tvalid = valid_q[NS-1];
  assign m_axis_tdata  = {bo_q, go_q, ro_q};
  assign m_axis_tlast  = last7_q;

`ifndef ASSERT_OFF
  // An empty output register lets the whole pipeline move.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[NS-1] |-> s_axis_tready)
    else $error("input not ready although the output stage is empty");

  // Saturation never exceeds one at the end of the divider.
  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[hsa_pkg::DIV_STAGES] |-> (dv_last.sat.quo <= 19'(hsa_pkg::ONE_Q16)))
    else $error("saturation quotient above one");

  // The hue quotient always lands in one of the six sectors.
  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[hsa_pkg::DIV_STAGES] |-> (dv_last.hue.quo[18:16] <= 3'd5))
    else $error("hue sector out of range");

  // Divider remainders stay below their divisors.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[2] |-> (dv_q[2].sat.rem < dv_q[2].sat_den) && (dv_q[2].hue.rem < dv_q[2].hue_den))
    else $error("divider remainder not below divisor");
`endif

endmodule
